// File: sv/rcwl_pkg.sv
// Package: shared constants, types and codes for the reset count wear-level log unit.
`timescale 1ns / 1ps
package rcwl_pkg;

    localparam int LOG_CELLS = 4096;
    localparam int ADDR_W    = $clog2(LOG_CELLS);
    localparam int DATA_W    = 8;
    localparam int TIME_W    = 32;
    localparam int MASK_W    = 7;
    localparam int REASON_W  = 3;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 32;

    localparam logic [DATA_W-1:0]    CELL_EMPTY    = 8'hFF;
    localparam logic [ADDR_W-1:0]    LAST_ADDR     = ADDR_W'(LOG_CELLS - 1);
    localparam logic [TIME_W-1:0]    TIMEOUT_RESET = 32'd10000;
    localparam logic [MASK_W-1:0]    MASK_RESET    = 7'd64;

    // Input action codes
    localparam logic ACT_BOOT = 1'b0;
    localparam logic ACT_TIME = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK    = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_DECIDE,
        ST_WRITE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
    } t_mem_req;

endpackage

// File: sv/reset_count_wear_level_log_unit.sv
// Top level: reset counter kept in a wear-levelled byte log.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+--------------------------------------------
//  command   | start, busy               | i_action, i_reset_reason, i_now_ms
//  result    | o_valid (one-cycle strobe)| o_reset_count, o_reset_was_counted,
//            |                           | o_still_monitoring
//  config    | i_cfg_we                  | i_cfg_idx, i_cfg_wdata
//
// A boot event, or a time check that times out, scans the log and, when it stores a
// value, rewrites every cell in a second pass over the single memory port. Other time
// checks skip both passes. After reset a clearing pass erases every cell of the log
// with busy high.
// The result strobe lasts one cycle; the receiver cannot stall it.
`timescale 1ns / 1ps
module reset_count_wear_level_log_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_action,
    input  logic [rcwl_pkg::REASON_W-1:0]  i_reset_reason,
    input  logic [rcwl_pkg::TIME_W-1:0]    i_now_ms,
    input  logic                           i_cfg_we,
    input  logic [rcwl_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rcwl_pkg::CFG_DAT_W-1:0] i_cfg_wdata,
    output logic                           o_valid,
    output logic [rcwl_pkg::DATA_W-1:0]    o_reset_count,
    output logic                           o_reset_was_counted,
    output logic                           o_still_monitoring
);
    import rcwl_pkg::*;

    t_mem_req          mem_req;
    logic [DATA_W-1:0] mem_rdata;

    rcwl_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    rcwl_ctrl u_ctrl (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .i_action            (i_action),
        .i_reset_reason      (i_reset_reason),
        .i_now_ms            (i_now_ms),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_rdata             (mem_rdata),
        .o_req               (mem_req),
        .busy                (busy),
        .o_valid             (o_valid),
        .o_reset_count       (o_reset_count),
        .o_reset_was_counted (o_reset_was_counted),
        .o_still_monitoring  (o_still_monitoring)
    );

endmodule

// File: sv/rcwl_ram.sv
// Log cell memory: one read/write port, registered read data.
`timescale 1ns / 1ps
module rcwl_ram (
    input  logic                      i_clk,
    input  rcwl_pkg::t_mem_req        i_req,
    output logic [rcwl_pkg::DATA_W-1:0] o_rdata
);
    import rcwl_pkg::*;

    logic [DATA_W-1:0] r_mem [LOG_CELLS];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.addr];
    end

endmodule

// File: sv/rcwl_ctrl.sv
// Sequencer: config registers, clearing pass, log scan and rewrite, result capture.
`timescale 1ns / 1ps
module rcwl_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic                          i_action,
    input  logic [rcwl_pkg::REASON_W-1:0] i_reset_reason,
    input  logic [rcwl_pkg::TIME_W-1:0]   i_now_ms,
    input  logic                          i_cfg_we,
    input  logic [rcwl_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rcwl_pkg::CFG_DAT_W-1:0] i_cfg_wdata,
    input  logic [rcwl_pkg::DATA_W-1:0]   i_rdata,
    output rcwl_pkg::t_mem_req            o_req,
    output logic                          busy,
    output logic                          o_valid,
    output logic [rcwl_pkg::DATA_W-1:0]   o_reset_count,
    output logic                          o_reset_was_counted,
    output logic                          o_still_monitoring
);
    import rcwl_pkg::*;

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_addr;
    logic              r_rd_vld;
    logic [ADDR_W-1:0] r_rd_addr;
    logic [1:0]        r_occ;
    logic [ADDR_W-1:0] r_first;
    logic [DATA_W-1:0] r_val;
    logic              r_is_boot;
    logic              r_count_op;
    logic [DATA_W-1:0] r_wr_val;
    logic [ADDR_W-1:0] r_target;
    logic [DATA_W-1:0] r_res_count;
    logic              r_res_counted;
    logic              r_res_mon;
    logic              r_waiting;
    logic              r_reason_cnt;
    logic [TIME_W-1:0] r_timeout;
    logic [MASK_W-1:0] r_mask;

    logic              accept;
    logic              last_addr;
    logic              reason_hit;
    logic              timed_out;
    logic [MASK_W:0]   mask_ext;
    logic [DATA_W-1:0] scan_cnt;

    assign accept     = start && (r_state == ST_IDLE);
    assign last_addr  = (r_addr == LAST_ADDR);
    // Code seven has no mask bit and never counts
    assign mask_ext   = {1'b0, r_mask};
    assign reason_hit = mask_ext[i_reset_reason];
    assign timed_out  = r_waiting && r_reason_cnt && (i_now_ms > r_timeout);
    assign scan_cnt   = (r_occ == 2'd1) ? r_val : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_req.we    = 1'b0;
        o_req.addr  = r_addr;
        o_req.wdata = CELL_EMPTY;
        unique case (r_state)
            ST_CLEAR: begin
                o_req.we = 1'b1;
                if (last_addr) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    if (i_action == ACT_BOOT || timed_out) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                if (last_addr) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                // time checks only scan when they reset the stored count to zero
                if (!r_is_boot || r_count_op) begin
                    n_state = ST_WRITE;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_WRITE: begin
                o_req.we    = 1'b1;
                o_req.wdata = (r_addr == r_target) ? r_wr_val : CELL_EMPTY;
                if (last_addr) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Address sweep and read pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr   <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= (r_state == ST_SCAN);
            if (r_state == ST_CLEAR || r_state == ST_SCAN || r_state == ST_WRITE) begin
                r_addr <= last_addr ? '0 : r_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_addr <= r_addr;
        if (accept) begin
            r_occ <= 2'd0;
        end else if (r_rd_vld && i_rdata != CELL_EMPTY) begin
            if (r_occ == 2'd0) begin
                r_first <= r_rd_addr;
            end
            // saturate: two or more occupied cells read as count zero
            r_occ <= (r_occ == 2'd2) ? 2'd2 : r_occ + 2'd1;
            r_val <= i_rdata;
        end
    end

    // Transaction capture and result
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_is_boot     <= (i_action == ACT_BOOT);
            r_count_op    <= reason_hit;
            r_res_count   <= '0;
            r_res_counted <= (i_action == ACT_BOOT) && reason_hit;
            r_res_mon     <= (i_action == ACT_TIME) && r_waiting && r_reason_cnt;
        end
        if (r_state == ST_DECIDE) begin
            r_wr_val <= r_is_boot ? scan_cnt + 1'b1 : '0;
            r_target <= (r_occ == 2'd0 || r_first == LAST_ADDR) ? '0 : r_first + 1'b1;
            if (r_is_boot) begin
                r_res_count <= r_count_op ? scan_cnt + 1'b1 : scan_cnt;
            end
        end
    end

    // Monitoring flags and config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waiting    <= 1'b0;
            r_reason_cnt <= 1'b0;
            r_timeout    <= TIMEOUT_RESET;
            r_mask       <= MASK_RESET;
        end else begin
            if (accept) begin
                if (i_action == ACT_BOOT) begin
                    r_waiting    <= 1'b1;
                    r_reason_cnt <= reason_hit;
                end else if (timed_out) begin
                    r_waiting <= 1'b0;
                end
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_TIMEOUT: r_timeout <= i_cfg_wdata[TIME_W-1:0];
                    CFG_MASK:    r_mask    <= i_cfg_wdata[MASK_W-1:0];
                    default:     ;
                endcase
            end
        end
    end

    assign busy                = (r_state != ST_IDLE);
    assign o_valid             = (r_state == ST_DONE);
    assign o_reset_count       = r_res_count;
    assign o_reset_was_counted = r_res_counted;
    assign o_still_monitoring  = r_res_mon;

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN || r_state == ST_FLUSH) |-> !o_req.we)
        else $error("log written during scan");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DECIDE) |-> (r_occ != 2'd3))
        else $error("occupied count out of range");

endmodule

// File: verif/tb_reset_count_wear_level_log_unit.sv
// Testbench for the reset count wear-level log unit: directed and random checks.
`timescale 1ns / 1ps
module tb_reset_count_wear_level_log_unit;
    import rcwl_pkg::*;

    // Slowest transactions, a counted boot or a timed-out check: two full passes over the log.
    localparam int WATCHDOG_LIMIT = 10 * LOG_CELLS + 1000;
    localparam int RANDOM_ITEMS   = 80;

    localparam logic [REASON_W-1:0] REASON_NEVER   = 3'd7;  // no mask bit exists for it
    localparam logic [REASON_W-1:0] REASON_DEFAULT = 3'd6;  // counted by the reset mask
    localparam logic [REASON_W-1:0] REASON_ZERO    = 3'd0;

    typedef struct packed {
        logic [DATA_W-1:0] count;
        logic              counted;
        logic              monitoring;
    } t_count_result;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 start          = 1'b0;
    logic                 busy;
    logic                 i_action       = ACT_BOOT;
    logic [REASON_W-1:0]  i_reset_reason = '0;
    logic [TIME_W-1:0]    i_now_ms       = '0;
    logic                 i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx      = CFG_TIMEOUT;
    logic [CFG_DAT_W-1:0] i_cfg_wdata    = '0;
    logic                 o_valid;
    logic [DATA_W-1:0]    o_reset_count;
    logic                 o_reset_was_counted;
    logic                 o_still_monitoring;

    // Shadow of the block: byte log, flags and registers
    logic [DATA_W-1:0] log_copy [LOG_CELLS];
    logic              monitoring_on;
    logic              reason_on;
    logic [TIME_W-1:0] timeout_copy;
    logic [MASK_W-1:0] mask_copy;

    t_count_result     pending_counts [$];
    int                errors       = 0;
    int                stall_cycles = 0;
    int                burst_left   = 1;
    logic [TIME_W-1:0] cur_timeout  = TIMEOUT_RESET;

    reset_count_wear_level_log_unit DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_action            (i_action),
        .i_reset_reason      (i_reset_reason),
        .i_now_ms            (i_now_ms),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_wdata         (i_cfg_wdata),
        .o_valid             (o_valid),
        .o_reset_count       (o_reset_count),
        .o_reset_was_counted (o_reset_was_counted),
        .o_still_monitoring  (o_still_monitoring)
    );

    always #5 i_clk = ~i_clk;

    // Count is valid only when exactly one cell holds data.
    function automatic logic [DATA_W-1:0] count_in_log();
        int                occupied = 0;
        logic [DATA_W-1:0] value    = '0;
        for (int i = 0; i < LOG_CELLS; i++) begin
            if (log_copy[i] != CELL_EMPTY) begin
                occupied++;
                value = log_copy[i];
            end
        end
        return (occupied == 1) ? value : '0;
    endfunction

    // Erase occupied cells, then place the value one past the first of them.
    function automatic void store_in_log(input logic [DATA_W-1:0] value);
        int first = -1;
        for (int i = 0; i < LOG_CELLS; i++) begin
            if (log_copy[i] != CELL_EMPTY) begin
                if (first < 0) first = i;
                log_copy[i] = CELL_EMPTY;
            end
        end
        if (first < 0 || first + 1 >= LOG_CELLS) first = 0;
        else first = first + 1;
        log_copy[first] = value;
    endfunction

    function automatic t_count_result predict_count(input logic act,
                                                    input logic [REASON_W-1:0] rsn,
                                                    input logic [TIME_W-1:0] now);
        t_count_result     res;
        logic [DATA_W-1:0] cnt;
        res = '0;
        if (act == ACT_BOOT) begin
            cnt           = count_in_log();
            reason_on     = (rsn != REASON_NEVER) ? mask_copy[rsn] : 1'b0;
            monitoring_on = 1'b1;
            if (reason_on) begin
                cnt         = cnt + 8'd1;
                store_in_log(cnt);
                res.counted = 1'b1;
            end
            res.count = cnt;
        end else if (monitoring_on && reason_on) begin
            if (now > timeout_copy) begin
                monitoring_on = 1'b0;
                store_in_log('0);
            end
            res.monitoring = 1'b1;
        end
        return res;
    endfunction

    task automatic compare_field(input string what, input logic [DATA_W-1:0] want,
                                 input logic [DATA_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
            errors++;
        end
    endtask

    // Check results, track register writes, predict accepted commands.
    always @(posedge i_clk) begin
        t_count_result want;
        if (i_rst_n) begin
            if (o_valid) begin
                if (pending_counts.size() == 0) begin
                    $display("%0t: unexpected transaction: expected none actual %0d/%0b/%0b",
                             $time, o_reset_count, o_reset_was_counted, o_still_monitoring);
                    errors++;
                end else begin
                    want = pending_counts.pop_front();
                    compare_field("reset_count", want.count, o_reset_count);
                    compare_field("reset_was_counted", DATA_W'(want.counted),
                                  DATA_W'(o_reset_was_counted));
                    compare_field("still_monitoring", DATA_W'(want.monitoring),
                                  DATA_W'(o_still_monitoring));
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_TIMEOUT) timeout_copy = i_cfg_wdata[TIME_W-1:0];
                else if (i_cfg_idx == CFG_MASK) mask_copy = i_cfg_wdata[MASK_W-1:0];
            end
            if (start && !busy)
                pending_counts.push_back(predict_count(i_action, i_reset_reason, i_now_ms));
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || i_cfg_we) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Work in bursts; drop start for a random gap between them.
    task automatic sender_pace();
        int gap;
        burst_left--;
        if (burst_left <= 0) begin
            gap        = $urandom_range(12, 1);
            burst_left = ($urandom_range(3) == 0) ? $urandom_range(40, 20)
                                                   : $urandom_range(6, 1);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_cmd(input logic act, input logic [REASON_W-1:0] rsn,
                            input logic [TIME_W-1:0] now);
        start          <= 1'b1;
        i_action       <= act;
        i_reset_reason <= rsn;
        i_now_ms       <= now;
        do @(posedge i_clk); while (busy);
        sender_pace();
    endtask

    // Hold off until every pending result has arrived and the block is idle.
    task automatic drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_counts.size() != 0 || busy);
    endtask

    task automatic configure(input logic [TIME_W-1:0] timeout,
                             input logic [CFG_DAT_W-1:0] mask_word);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_TIMEOUT;
        i_cfg_wdata <= timeout;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_MASK;
        i_cfg_wdata <= mask_word;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_timeout  = timeout;
    endtask

    task automatic test_reset_defaults();
        send_cmd(ACT_TIME, REASON_ZERO, '1);              // time check before any boot
        send_cmd(ACT_BOOT, REASON_DEFAULT, '0);
        send_cmd(ACT_TIME, REASON_ZERO, TIMEOUT_RESET);   // equal to timeout: keep waiting
        send_cmd(ACT_BOOT, REASON_ZERO, '1);              // reason not counted
        send_cmd(ACT_TIME, REASON_DEFAULT, '1);
        send_cmd(ACT_BOOT, REASON_DEFAULT, '0);
        send_cmd(ACT_TIME, REASON_ZERO, TIMEOUT_RESET + 1);
        send_cmd(ACT_TIME, REASON_ZERO, '1);              // monitoring has ended
        send_cmd(ACT_BOOT, REASON_DEFAULT, '0);
    endtask

    task automatic test_mask_extremes();
        configure('0, 32'h0000_007F);
        for (int r = 0; r < 7; r++) send_cmd(ACT_BOOT, REASON_W'(r), $urandom);
        send_cmd(ACT_TIME, REASON_ZERO, '0);
        send_cmd(ACT_TIME, REASON_ZERO, 32'd1);
        send_cmd(ACT_BOOT, REASON_NEVER, '1);
        send_cmd(ACT_TIME, REASON_NEVER, '1);
        configure(32'd500, 32'hFFFF_FF80);
        send_cmd(ACT_BOOT, REASON_DEFAULT, '0);
    endtask

    task automatic test_timeout_extremes();
        configure('1, 32'h0000_007F);
        send_cmd(ACT_BOOT, 3'd5, '0);
        send_cmd(ACT_TIME, REASON_ZERO, '1);
        configure(32'hFFFF_FFFE, 32'h0000_007F);
        send_cmd(ACT_TIME, REASON_ZERO, '1);
        send_cmd(ACT_TIME, REASON_ZERO, '0);
    endtask

    // Mostly boot-then-check sequences, with single random commands as noise.
    task automatic test_random();
        int                   sent;
        int                   since_cfg;
        int                   checks;
        logic [TIME_W-1:0]    tmo;
        logic [CFG_DAT_W-1:0] mask_word;
        sent      = 0;
        since_cfg = 0;
        while (sent < RANDOM_ITEMS) begin
            if (since_cfg >= 20) begin
                case ($urandom_range(3))
                    0:       tmo = '0;
                    1:       tmo = '1;
                    2:       tmo = $urandom_range(20000);
                    default: tmo = $urandom;
                endcase
                mask_word = $urandom;
                case ($urandom_range(5))
                    0:       mask_word[MASK_W-1:0] = '0;
                    1:       mask_word[MASK_W-1:0] = '1;
                    default: ;
                endcase
                configure(tmo, mask_word);
                since_cfg = 0;
            end
            if ($urandom_range(9) < 7) begin
                send_cmd(ACT_BOOT, REASON_W'($urandom_range(7)), $urandom);
                checks = $urandom_range(4);
                for (int j = 0; j < checks; j++)
                    send_cmd(ACT_TIME, REASON_W'($urandom_range(7)),
                             $urandom_range(cur_timeout, 0));
                sent += checks + 1;
                if ($urandom_range(9) < 7 && cur_timeout != '1) begin
                    send_cmd(ACT_TIME, REASON_W'($urandom_range(7)),
                             $urandom_range(32'hFFFF_FFFF, cur_timeout + 1));
                    sent++;
                end
            end else begin
                send_cmd(1'($urandom_range(1)), REASON_W'($urandom_range(7)), $urandom);
                sent++;
            end
            since_cfg = since_cfg + 1 + (sent % 4);
        end
    endtask

    initial begin
        foreach (log_copy[i]) log_copy[i] = CELL_EMPTY;
        monitoring_on = 1'b0;
        reason_on     = 1'b0;
        timeout_copy  = TIMEOUT_RESET;
        mask_copy     = MASK_RESET;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        drain_results();    // wait out the clearing pass

        test_reset_defaults();
        test_mask_extremes();
        test_timeout_extremes();
        test_random();

        drain_results();
        repeat (2 * LOG_CELLS + 16) @(posedge i_clk);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
